FILE: rtl/conv3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants
// Request payloads, register indexes and fixed sizes of the 3x3 filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int KSIZE      = 3;
  localparam int TAPS       = KSIZE * KSIZE;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int POS_W      = 16;
  localparam int SLOT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KA_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KA_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KA_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KB_ROW0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KB_ROW1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KB_ROW2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_B   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 3'd7;

  localparam logic KIND_PIXEL = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       frame_last;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/conv3x3_gray_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_gray_filter: streaming 3x3 gray-image convolution
// Raster-order pixels in, one filtered and clamped pixel per position out,
// zero padding at the frame edges, optional gradient magnitude of two kernels.
// ----------------------------------------------------------------------------
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------
//   pix     | pix_valid / pix_stall     | pix_item  (kind, pixel)
//   res     | res_valid / res_stall     | res_item  (out_pixel, frame_last)
//   cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Sequence: a request that yields no result ends at accept. A request with a
//   result passes accept, 9 line store reads on its single read port, chain
//   settling, rounding and output, plus a square and 8 root steps in
//   magnitude mode.
// Reset: counters and state cleared, configuration set to its defaults; no
//   clearing pass, line store data is only used where it was written in the current frame.
// Stalls: res_stall only holds the output register; a new pix request is
//   taken while a result waits, and the block waits at the output step only.
//
// ----------------------------------------------------------------------------
module conv3x3_gray_filter #(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pix_valid,
  output logic                                     pix_stall,
  input  wire conv3_pkg::in_item_t                 pix_item,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output conv3_pkg::out_item_t                     res_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import conv3_pkg::*;

  localparam int DEPTH  = 3 * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACC_W  = COEF_BITS + 13;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration
  logic [CFG_DATA_W-1:0] kern_a [KSIZE];
  logic [CFG_DATA_W-1:0] kern_b [KSIZE];
  logic                  use_b;
  logic [31:0]           image_size;

  // frame position
  logic [POS_W-1:0] in_row, in_col, out_row, out_col;
  logic [1:0]       in_slot, out_slot;

  // latched emit position
  logic [POS_W-1:0] e_row, e_col;
  logic [1:0]       e_slot;
  logic             e_last;

  logic [2:0] state;
  logic [1:0] k_cnt, l_cnt;
  logic [3:0] sum_cnt;
  logic       ld_en, ld_pad;

  logic signed [ACC_W-1:0] a_val, b_val;
  logic [16:0] sq;
  logic        big;
  logic [7:0]  root, bitm;

  // frame dimensions
  logic [POS_W-1:0] w, h;
  always_comb begin
    w = image_size[15:0];
    if (w == '0) w = POS_W'(1);
    if (w > POS_W'(MAX_WIDTH)) w = POS_W'(MAX_WIDTH);
    h = image_size[31:16];
    if (h == '0) h = POS_W'(1);
  end

  // next input position and emit decision
  logic             accept, done, is_pixel, emit_cond, emit_go, last_c;
  logic [POS_W:0]   col_inc, ocol_inc;
  logic             wrap, owrap;
  logic [POS_W-1:0] nrow, ncol;
  logic [1:0]       nslot;

  assign accept   = pix_valid && !pix_stall;
  assign done     = in_row >= h;
  assign is_pixel = pix_item.kind == KIND_PIXEL;

  always_comb begin
    col_inc = {1'b0, in_col} + 1'b1;
    wrap    = col_inc >= {1'b0, w};
    nrow    = wrap ? in_row + 1'b1 : in_row;
    ncol    = wrap ? '0 : col_inc[POS_W-1:0];
    nslot   = wrap ? ((in_slot == 2'd2) ? 2'd0 : in_slot + 2'd1) : in_slot;
    // received >= w + 2, then one position written out per pixel
    emit_cond = ((nrow >= POS_W'(2)) && ((w != POS_W'(1)) || (nrow >= POS_W'(3))))
              || ((nrow == POS_W'(1)) && (ncol >= POS_W'(2)));
    emit_go   = done || (is_pixel && emit_cond);
    ocol_inc  = {1'b0, out_col} + 1'b1;
    owrap     = ocol_inc >= {1'b0, w};
    last_c    = (out_row == h - 1'b1) && (out_col == w - 1'b1);
  end

  // line store addressing
  logic             ram_we, ram_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]       rdata;
  logic [1:0]       rd_slot;
  logic             pad;
  logic [POS_W-1:0] rd_col;

  assign ram_we = accept && !done && is_pixel;
  assign waddr  = ADDR_W'(in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign ram_re = state == S_READ;

  always_comb begin
    pad = 1'b0;
    case (k_cnt)
      2'd0: begin
        rd_slot = (e_slot == 2'd0) ? 2'd2 : e_slot - 2'd1;
        pad     = e_row == '0;
      end
      2'd1: begin
        rd_slot = e_slot;
      end
      default: begin
        rd_slot = (e_slot == 2'd2) ? 2'd0 : e_slot + 2'd1;
        pad     = ({1'b0, e_row} + 1'b1) >= {1'b0, h};
      end
    endcase
    if (l_cnt == 2'd0 && e_col == '0) pad = 1'b1;
    if (l_cnt == 2'd2 && (({1'b0, e_col} + 1'b1) >= {1'b0, w})) pad = 1'b1;
    rd_col = e_col + POS_W'(l_cnt) - 1'b1;
    raddr  = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
  end

  conv3_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (pix_item.pixel),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // window cell chain; cell i ends up holding window tap TAPS-1-i
  logic [7:0]              pix_link [TAPS+1];
  logic signed [ACC_W-1:0] acca_link [TAPS+1];
  logic signed [ACC_W-1:0] accb_link [TAPS+1];

  assign pix_link[0]  = ld_pad ? 8'd0 : rdata;
  assign acca_link[0] = '0;
  assign accb_link[0] = '0;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int TAP = TAPS - 1 - i;
    localparam int KR  = TAP / KSIZE;
    localparam int KC  = TAP % KSIZE;
    logic [SLOT_W-1:0] slot_a, slot_b;
    assign slot_a = kern_a[KR][(KSIZE-1-KC)*SLOT_W +: SLOT_W];
    assign slot_b = kern_b[KR][(KSIZE-1-KC)*SLOT_W +: SLOT_W];
    conv3_cell #(.COEF_BITS(COEF_BITS), .ACC_W(ACC_W)) u_cell (
      .clk      (clk),
      .shift_en (ld_en),
      .pix_in   (pix_link[i]),
      .pix_out  (pix_link[i+1]),
      .coef_a   ($signed(slot_a[COEF_BITS-1:0])),
      .coef_b   ($signed(slot_b[COEF_BITS-1:0])),
      .acc_a_in (acca_link[i]),
      .acc_b_in (accb_link[i]),
      .acc_a    (acca_link[i+1]),
      .acc_b    (accb_link[i+1])
    );
  end

  // Q8.8 to integer, toward zero
  function automatic logic signed [ACC_W-1:0] trunc8(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x[ACC_W-1] ? x + ACC_W'(255) : x;
    return y >>> 8;
  endfunction

  logic [ACC_W-1:0] a_abs, b_abs;
  logic [7:0]       root_t;
  logic [15:0]      root_sq;
  logic [7:0]       res_val;
  logic             can_load;

  always_comb begin
    a_abs   = a_val[ACC_W-1] ? ACC_W'(-a_val) : ACC_W'(a_val);
    b_abs   = b_val[ACC_W-1] ? ACC_W'(-b_val) : ACC_W'(b_val);
    root_t  = root | bitm;
    root_sq = {8'd0, root_t} * {8'd0, root_t};
    if (use_b) begin
      res_val = big ? 8'd255 : root;
    end else if (a_val[ACC_W-1]) begin
      res_val = 8'd0;
    end else if (a_val > ACC_W'(255)) begin
      res_val = 8'd255;
    end else begin
      res_val = a_val[7:0];
    end
  end

  assign can_load  = !res_valid || !res_stall;
  assign pix_stall = state != S_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_row     <= '0;
      in_col     <= '0;
      in_slot    <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_slot   <= '0;
      k_cnt      <= '0;
      l_cnt      <= '0;
      sum_cnt    <= '0;
      ld_en      <= 1'b0;
      res_valid  <= 1'b0;
      kern_a[0]  <= '0;
      kern_a[1]  <= 48'h0000_0100_0000;
      kern_a[2]  <= '0;
      kern_b[0]  <= '0;
      kern_b[1]  <= '0;
      kern_b[2]  <= '0;
      use_b      <= 1'b0;
      image_size <= 32'd31458560;
    end else begin
      ld_en  <= ram_re;
      ld_pad <= pad;

      if (state == S_OUT && can_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (ram_we) begin
              in_row  <= nrow;
              in_col  <= ncol;
              in_slot <= nslot;
            end
            if (emit_go) begin
              e_row  <= out_row;
              e_col  <= out_col;
              e_slot <= out_slot;
              e_last <= last_c;
              k_cnt  <= '0;
              l_cnt  <= '0;
              state  <= S_READ;
              if (last_c) begin
                // frame done: all positions back to the start
                in_row   <= '0;
                in_col   <= '0;
                in_slot  <= '0;
                out_row  <= '0;
                out_col  <= '0;
                out_slot <= '0;
              end else if (owrap) begin
                out_col  <= '0;
                out_row  <= out_row + 1'b1;
                out_slot <= (out_slot == 2'd2) ? 2'd0 : out_slot + 2'd1;
              end else begin
                out_col <= ocol_inc[POS_W-1:0];
              end
            end
          end
        end
        S_READ: begin
          if (l_cnt == 2'd2) begin
            l_cnt <= '0;
            k_cnt <= k_cnt + 2'd1;
            if (k_cnt == 2'd2) begin
              sum_cnt <= '0;
              state   <= S_SUM;
            end
          end else begin
            l_cnt <= l_cnt + 2'd1;
          end
        end
        S_SUM: begin
          // last tap lands, then the sums ripple through all cells
          sum_cnt <= sum_cnt + 4'd1;
          if (sum_cnt == 4'd9) state <= S_POST;
        end
        S_POST: begin
          a_val <= trunc8(acca_link[TAPS]);
          b_val <= trunc8(accb_link[TAPS]);
          state <= use_b ? S_SQ : S_OUT;
        end
        S_SQ: begin
          // either side at 255 or more caps the root
          big   <= (a_abs >= ACC_W'(255)) || (b_abs >= ACC_W'(255));
          sq    <= 17'({8'd0, a_abs[7:0]} * {8'd0, a_abs[7:0]})
                 + 17'({8'd0, b_abs[7:0]} * {8'd0, b_abs[7:0]});
          root  <= '0;
          bitm  <= 8'h80;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if ({1'b0, root_sq} <= sq) root <= root_t;
          bitm <= bitm >> 1;
          if (bitm[0]) state <= S_OUT;
        end
        S_OUT: begin
          if (can_load) begin
            res_item.out_pixel  <= res_val;
            res_item.frame_last <= e_last;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KA_ROW0: kern_a[0] <= cfg_data;
          CFG_KA_ROW1: kern_a[1] <= cfg_data;
          CFG_KA_ROW2: kern_a[2] <= cfg_data;
          CFG_KB_ROW0: kern_b[0] <= cfg_data;
          CFG_KB_ROW1: kern_b[1] <= cfg_data;
          CFG_KB_ROW2: kern_b[2] <= cfg_data;
          CFG_USE_B:   use_b     <= cfg_data[0];
          CFG_SIZE: begin
            // new size restarts the frame
            image_size <= cfg_data[31:0];
            in_row     <= '0;
            in_col     <= '0;
            in_slot    <= '0;
            out_row    <= '0;
            out_col    <= '0;
            out_slot   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/conv3_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module conv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/conv3_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_cell: one window tap
// Holds one pixel of the window, passes it on when shifting, and adds its
// two coefficient products to the partial sums coming from its neighbor.
// ----------------------------------------------------------------------------
module conv3_cell #(
  parameter int COEF_BITS = 16,
  parameter int ACC_W     = 29
) (
  input  wire logic                        clk,
  input  wire logic                        shift_en,
  input  wire logic [7:0]                  pix_in,
  output logic      [7:0]                  pix_out,
  input  wire logic signed [COEF_BITS-1:0] coef_a,
  input  wire logic signed [COEF_BITS-1:0] coef_b,
  input  wire logic signed [ACC_W-1:0]     acc_a_in,
  input  wire logic signed [ACC_W-1:0]     acc_b_in,
  output logic signed [ACC_W-1:0]          acc_a,
  output logic signed [ACC_W-1:0]          acc_b
);

  logic signed [8:0]           pix_s;
  logic signed [COEF_BITS+8:0] prod_a;
  logic signed [COEF_BITS+8:0] prod_b;

  assign pix_s  = $signed({1'b0, pix_out});
  assign prod_a = (COEF_BITS+9)'(coef_a) * (COEF_BITS+9)'(pix_s);
  assign prod_b = (COEF_BITS+9)'(coef_b) * (COEF_BITS+9)'(pix_s);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_out <= pix_in;
    end
    acc_a <= acc_a_in + ACC_W'(prod_a);
    acc_b <= acc_b_in + ACC_W'(prod_b);
  end

endmodule
`default_nettype wire
